// File: hw/rtl/fce_pkg.sv
// Package for the flip candidate enumerator: sizing constants, controller state
// type, command/status structs and the highest-set-bit helper.
// No dependencies.
package fce_pkg;

    localparam int MAX_FLIP_BITS = 6;
    localparam int HASH_W        = 32;
    localparam int IDX_W         = MAX_FLIP_BITS;
    localparam int USED_W        = $clog2(MAX_FLIP_BITS + 1);

    typedef logic [HASH_W-1:0] word_t;
    typedef logic [IDX_W-1:0]  idx_t;
    typedef logic [USED_W-1:0] used_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic capture;
        logic scan_step;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic scan_done;
        logic out_fire;
        logic out_last;
    } status_t;

    // One-hot of the most significant set bit; zero for a zero word.
    function automatic word_t highest_bit(input word_t x);
        word_t smear;
        smear = x;
        smear = smear | (smear >> 1);
        smear = smear | (smear >> 2);
        smear = smear | (smear >> 4);
        smear = smear | (smear >> 8);
        smear = smear | (smear >> 16);
        return x & ~(smear >> 1);
    endfunction

endpackage

// File: hw/rtl/fce_ctrl.sv
// Controller state machine for the flip candidate enumerator.
// Depends on fce_pkg.
module fce_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  fce_pkg::status_t status,
    output fce_pkg::cmd_t    cmd
);

    fce_pkg::state_t state_reg;
    fce_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fce_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            fce_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = fce_pkg::ST_SCAN;
                end
            end
            fce_pkg::ST_SCAN:
            begin
                if (status.scan_done)
                begin
                    state_next = fce_pkg::ST_EMIT;
                end
            end
            fce_pkg::ST_EMIT:
            begin
                if (status.out_fire && status.out_last)
                begin
                    state_next = fce_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = fce_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready      = 1'b0;
        cmd.capture   = 1'b0;
        cmd.scan_step = 1'b0;
        cmd.load_out  = 1'b0;
        case (state_reg)
            fce_pkg::ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
            end
            fce_pkg::ST_SCAN:
            begin
                cmd.scan_step = !status.scan_done;
                cmd.load_out  = status.scan_done;
            end
            fce_pkg::ST_EMIT:
            begin
            end
            default:
            begin
            end
        endcase
    end

endmodule

// File: hw/rtl/fce_datapath.sv
// Datapath for the flip candidate enumerator: mask scan, selected-bit store,
// candidate counter and the output register.
// Depends on fce_pkg.
module fce_datapath
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  fce_pkg::word_t        hash_word,
    input  fce_pkg::word_t        toggle_mask,
    input  fce_pkg::cmd_t         cmd,
    output fce_pkg::status_t      status,
    output logic                  out_valid,
    input  logic                  out_ready,
    output fce_pkg::word_t        candidate,
    output logic                  last,
    output logic                  overflow
);

    fce_pkg::word_t hash_reg;
    fce_pkg::word_t rem_reg;
    fce_pkg::word_t sel_reg [fce_pkg::MAX_FLIP_BITS];
    fce_pkg::used_t used_reg;
    fce_pkg::idx_t  idx_reg;
    fce_pkg::word_t cand_reg;
    logic           last_reg;
    logic           ovf_reg;
    logic           out_valid_reg;

    fce_pkg::word_t top_bit;
    fce_pkg::idx_t  idx_limit;
    fce_pkg::idx_t  idx_next;
    fce_pkg::word_t flip_next;
    logic           fire;

    assign top_bit   = fce_pkg::highest_bit(rem_reg);
    // Index of the final candidate: 2^used - 1.
    assign idx_limit = ~({fce_pkg::IDX_W{1'b1}} << used_reg);
    assign idx_next  = idx_reg + fce_pkg::idx_t'(1);
    assign fire      = out_valid_reg && out_ready;

    always_comb
    begin
        flip_next = '0;
        for (int j = 0; j < fce_pkg::MAX_FLIP_BITS; j++)
        begin
            if (idx_next[j])
            begin
                flip_next = flip_next | sel_reg[j];
            end
        end
    end

    assign status.scan_done = (rem_reg == '0) ||
                              (used_reg == fce_pkg::used_t'(fce_pkg::MAX_FLIP_BITS));
    assign status.out_fire  = fire;
    assign status.out_last  = last_reg;

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            hash_reg <= hash_word;
        end
        if (cmd.scan_step)
        begin
            for (int j = 0; j < fce_pkg::MAX_FLIP_BITS; j++)
            begin
                if (used_reg == fce_pkg::used_t'(j))
                begin
                    sel_reg[j] <= top_bit;
                end
            end
        end
        if (cmd.load_out)
        begin
            cand_reg <= hash_reg;
            ovf_reg  <= (rem_reg != '0);
        end
        else if (fire && !last_reg)
        begin
            cand_reg <= hash_reg ^ flip_next;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg       <= '0;
            used_reg      <= '0;
            idx_reg       <= '0;
            last_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.capture)
            begin
                rem_reg  <= toggle_mask;
                used_reg <= '0;
            end
            else if (cmd.scan_step)
            begin
                rem_reg  <= rem_reg ^ top_bit;
                used_reg <= used_reg + fce_pkg::used_t'(1);
            end

            if (cmd.load_out)
            begin
                idx_reg       <= '0;
                last_reg      <= (idx_limit == '0);
                out_valid_reg <= 1'b1;
            end
            else if (fire)
            begin
                if (last_reg)
                begin
                    out_valid_reg <= 1'b0;
                end
                else
                begin
                    idx_reg  <= idx_next;
                    last_reg <= (idx_next == idx_limit);
                end
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign candidate = cand_reg;
    assign last      = last_reg;
    assign overflow  = ovf_reg;

endmodule

// File: hw/rtl/flip_candidate_enumerator.sv
// Top level of the flip candidate enumerator: joins the controller and the
// datapath. Depends on fce_pkg, fce_ctrl and fce_datapath.
//
// Each input transaction carries a 32-bit hash and a 32-bit toggle mask. The
// block returns 2^k output transactions, where k is the number of set mask
// bits in use (at most MAX_FLIP_BITS, taken from the most significant end).
// The first candidate is the hash unchanged; candidate i inverts the j-th
// selected mask bit whenever bit j of i is set. The final candidate of an
// input carries last, and every candidate carries overflow when the mask held
// more set bits than MAX_FLIP_BITS. After acceptance the datapath isolates
// one selected mask bit per cycle with a highest-set-bit finder, then the
// output register presents one candidate per cycle while out_ready is high.
// The next input is accepted once the last candidate of the current one has
// been taken.
module flip_candidate_enumerator
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [31:0]           hash_word,
    input  logic [31:0]           toggle_mask,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [31:0]           candidate,
    output logic                  last,
    output logic                  overflow
);

    fce_pkg::cmd_t    cmd;
    fce_pkg::status_t status;

    // The controller sequences capture, bit scan and candidate emission.
    fce_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // The datapath holds the operands, the selected bits and the output register.
    fce_datapath u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .hash_word   (hash_word),
        .toggle_mask (toggle_mask),
        .cmd         (cmd),
        .status      (status),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .candidate   (candidate),
        .last        (last),
        .overflow    (overflow)
    );

endmodule

// File: tb/flip_candidate_enumerator_tb.sv
// Self-checking testbench for the flip candidate enumerator.
// Depends on fce_pkg and flip_candidate_enumerator, and through it on fce_ctrl and fce_datapath.
module flip_candidate_enumerator_tb;

    // One expected output transaction: the candidate word and its two flags.
    typedef struct {
        fce_pkg::word_t cand;
        logic           is_last;
        logic           ovf;
    } cand_exp_t;

    logic           clk         = 1'b0;
    logic           rst_n       = 1'b0;
    logic           in_valid    = 1'b0;
    logic           in_ready;
    fce_pkg::word_t hash_word   = '0;
    fce_pkg::word_t toggle_mask = '0;
    logic           out_valid;
    logic           out_ready   = 1'b0;
    fce_pkg::word_t candidate;
    logic           last;
    logic           overflow;

    // Candidates still owed by the block, oldest at the front.
    cand_exp_t   pending_candidates[$];
    int unsigned error_count = 0;
    // When clear, neither side inserts idle cycles.
    bit          idle_enable = 1'b1;
    int unsigned stall_left  = 0;

    flip_candidate_enumerator u_top
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .hash_word   (hash_word),
        .toggle_mask (toggle_mask),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .candidate   (candidate),
        .last        (last),
        .overflow    (overflow)
    );

    always #2 clk = ~clk;

    // Works out every candidate that one accepted input transaction should
    // produce. The set mask bits are picked from the most significant end, and
    // only the first MAX_FLIP_BITS of them are ever inverted. Candidate number
    // i inverts picked bit j whenever bit j of i is set, so candidate 0 is the
    // hash itself and the all-ones index inverts every picked bit.
    task automatic predict_candidates(input fce_pkg::word_t h, input fce_pkg::word_t m);
        fce_pkg::word_t picked [fce_pkg::MAX_FLIP_BITS];
        int unsigned    n_used;
        int unsigned    n_set;
        int unsigned    n_cand;
        fce_pkg::word_t v;
        cand_exp_t      e;
        begin
            n_used = 0;
            n_set  = 0;
            for (int b = fce_pkg::HASH_W - 1; b >= 0; b--)
            begin
                if (m[b])
                begin
                    if (n_used < fce_pkg::MAX_FLIP_BITS)
                    begin
                        picked[n_used] = fce_pkg::word_t'(1) << b;
                        n_used++;
                    end
                    n_set++;
                end
            end
            n_cand = 1 << n_used;
            for (int i = 0; i < n_cand; i++)
            begin
                v = h;
                for (int j = 0; j < n_used; j++)
                begin
                    if (i[j])
                        v = v ^ picked[j];
                end
                e.cand    = v;
                e.is_last = (i == n_cand - 1);
                e.ovf     = (n_set > n_used);
                pending_candidates.insert(pending_candidates.size(), e);
            end
        end
    endtask

    // A mask with exactly k set bits at random positions.
    function automatic fce_pkg::word_t mask_with_bits(input int unsigned k);
        fce_pkg::word_t m;
        begin
            m = '0;
            while ($countones(m) < k)
                m[$urandom_range(fce_pkg::HASH_W - 1, 0)] = 1'b1;
            return m;
        end
    endfunction

    // Sends one input transaction. It is always entered just after a rising
    // edge. Valid is only lowered when an idle burst precedes the item, so a
    // back-to-back item never sees valid dropped and raised in one time step.
    // The expectation is recorded at the edge where the handshake completes.
    task automatic send_item(input fce_pkg::word_t h, input fce_pkg::word_t m);
        int unsigned gap;
        begin
            gap = 0;
            if (idle_enable && $urandom_range(3, 0) == 0)
                gap = $urandom_range(3, 1);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            in_valid    <= 1'b1;
            hash_word   <= h;
            toggle_mask <= m;
            do
                @(posedge clk);
            while (!in_ready);
            predict_candidates(h, m);
        end
    endtask

    // Drops valid and holds off until every owed candidate has been seen. At
    // least one edge passes so that valid is never driven twice in one step.
    task automatic wait_for_drain;
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while (pending_candidates.size() != 0)
                @(posedge clk);
        end
    endtask

    // Receiver: checks each output transaction against the oldest expectation
    // and throttles out_ready in short random bursts. All values are sampled
    // as they stood just before the edge.
    always @(posedge clk)
    begin
        cand_exp_t exp_c;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_candidates.size() == 0)
            begin
                $display("%0t unexpected result: candidate %h last %b overflow %b",
                         $time, candidate, last, overflow);
                error_count++;
            end
            else
            begin
                exp_c = pending_candidates.pop_front();
                if (candidate !== exp_c.cand)
                begin
                    $display("%0t candidate mismatch: expected %h actual %h",
                             $time, exp_c.cand, candidate);
                    error_count++;
                end
                if (last !== exp_c.is_last)
                begin
                    $display("%0t last mismatch: expected %b actual %b",
                             $time, exp_c.is_last, last);
                    error_count++;
                end
                if (overflow !== exp_c.ovf)
                begin
                    $display("%0t overflow mismatch: expected %b actual %b",
                             $time, exp_c.ovf, overflow);
                    error_count++;
                end
            end
        end
        if (idle_enable && stall_left == 0 && $urandom_range(4, 0) == 0)
            stall_left = $urandom_range(3, 1);
        if (stall_left != 0)
        begin
            out_ready <= 1'b0;
            stall_left--;
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    // Extremes of both fields, single bits at either end, exactly the limit
    // of selectable bits, one bit beyond it, a full mask and the empty mask.
    task automatic test_directed;
        begin
            send_item(32'h0000_0000, 32'h0000_0000);
            send_item(32'hFFFF_FFFF, 32'h0000_0000);
            send_item(32'h0000_0000, 32'h8000_0000);
            send_item(32'hFFFF_FFFF, 32'h0000_0001);
            send_item(32'h8000_0000, 32'h8000_0000);
            send_item(32'h0000_0001, 32'h0000_0001);
            send_item(32'hA5A5_A5A5, 32'h8000_0001);
            send_item(32'h1234_5678, 32'hFC00_0000);
            send_item(32'h0000_0000, 32'h0000_003F);
            send_item(32'hFFFF_FFFF, 32'hFE00_0000);
            send_item(32'h0000_0000, 32'h0000_007F);
            send_item(32'hDEAD_BEEF, 32'hFFFF_FFFF);
            send_item(32'h0000_0000, 32'hAAAA_AAAA);
            send_item(32'hFFFF_FFFF, 32'h5555_5555);
            send_item(32'h5A5A_5A5A, 32'h0001_0001);
            send_item(32'hFFFF_FFFF, 32'hFFFF_FFFF);
            wait_for_drain();
        end
    endtask

    // Only masks within the limit, so that every expansion depth is hit.
    task automatic test_random_sparse;
        begin
            repeat (110)
                send_item($urandom,
                          mask_with_bits($urandom_range(fce_pkg::MAX_FLIP_BITS, 0)));
            wait_for_drain();
        end
    endtask

    // Masks that exceed the limit, either fully random or densely populated.
    task automatic test_random_dense;
        begin
            repeat (20)
            begin
                if ($urandom_range(1, 0) == 0)
                    send_item($urandom, $urandom);
                else
                    send_item($urandom,
                              mask_with_bits($urandom_range(fce_pkg::HASH_W,
                                                            fce_pkg::MAX_FLIP_BITS + 1)));
            end
            wait_for_drain();
        end
    endtask

    // The sender waits for every owed candidate before the next item, so each
    // transaction meets an idle block.
    task automatic test_pause_until_drained;
        begin
            repeat (30)
            begin
                send_item($urandom,
                          mask_with_bits($urandom_range(fce_pkg::MAX_FLIP_BITS + 1, 0)));
                wait_for_drain();
            end
        end
    endtask

    // Final stretch with no idling on either side: back-to-back transactions.
    task automatic test_back_to_back;
        begin
            idle_enable = 1'b0;
            repeat (40)
            begin
                if ($urandom_range(7, 0) == 0)
                    send_item($urandom, $urandom);
                else
                    send_item($urandom,
                              mask_with_bits($urandom_range(fce_pkg::MAX_FLIP_BITS, 0)));
            end
            wait_for_drain();
        end
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random_sparse();
        test_pause_until_drained();
        test_random_dense();
        test_back_to_back();
        // A little extra time so that any stray result is caught.
        repeat (100) @(posedge clk);
        if (error_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Watchdog, several times the slowest legal run.
    initial
    begin
        #2000000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
